// File: rtl/mfg_pkg.sv
// Shared types, constants and micro-program for the mesh face geometry block.
`default_nettype none
package mfg_pkg;

  // Field and internal widths
  localparam int CW     = 32;   // input coordinate
  localparam int D_W    = 33;   // vertex difference
  localparam int SUM_W  = 40;   // per-axis coordinate sum, centroid
  localparam int OP_W   = 52;   // multiplier operand
  localparam int ACC_W  = 106;  // multiply-accumulate result
  localparam int CR_W   = 68;   // raw cross product, Q.32
  localparam int BR_W   = 86;   // raw binormal
  localparam int VEC_W  = 48;   // result vector component
  localparam int AREA_W = 47;   // result area
  localparam int AR_W   = 52;   // area accumulator
  localparam int RAD_W  = 104;  // square root radicand
  localparam int ROOT_W = 52;   // square root result
  localparam int VMAX   = 4;    // stored vertices
  localparam int VIDX_W = 2;
  localparam int NAX    = 3;    // axes
  localparam int PC_W   = 5;
  localparam int SH_QUAD = 16;
  localparam int SH_TRI  = 17;

  // Micro-program landmarks
  localparam logic [PC_W-1:0] PC_FIRST = 5'd0;
  localparam logic [PC_W-1:0] PC_SQ1   = 5'd8;
  localparam logic [PC_W-1:0] PC_DOT   = 5'd18;
  localparam logic [PC_W-1:0] PC_LAST  = 5'd26;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MAC_GO, ST_MAC_WAIT, ST_SQRT_WAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    KIND_CENTROID, KIND_NORMAL, KIND_TANGENT, KIND_BINORMAL
  } kind_t;

  typedef enum logic [4:0] {
    SRC_U0, SRC_U1, SRC_U2, SRC_E20, SRC_E21, SRC_E22, SRC_E30, SRC_E31, SRC_E32,
    SRC_C0, SRC_C1, SRC_C2, SRC_D0, SRC_D1, SRC_D2, SRC_N0, SRC_N1, SRC_N2
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_C0, DST_C1, DST_C2, DST_D0, DST_D1, DST_D2,
    DST_SQ, DST_FLIP, DST_B0, DST_B1, DST_B2
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    logic neg;
    logic first;
    dst_t dst;
  } uop_t;

  typedef struct packed {
    logic  vertex;
    logic  close;
    logic  mac_start;
    uop_t  uop;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mac_done;
    logic sqrt_done;
    logic good;
    logic quad;
  } status_t;

  function automatic uop_t mk(src_t a, src_t b, logic neg, logic first, dst_t dst);
    uop_t r;
    r.a = a;
    r.b = b;
    r.neg = neg;
    r.first = first;
    r.dst = dst;
    return r;
  endfunction

  // Multiply-accumulate program: first cross product and its area, second
  // triangle of a quad, orientation dot product, binormal.
  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t r;
    case (pc)
      5'd0:    r = mk(SRC_U1,  SRC_E22, 1'b0, 1'b1, DST_NONE);
      5'd1:    r = mk(SRC_U2,  SRC_E21, 1'b1, 1'b0, DST_C0);
      5'd2:    r = mk(SRC_U2,  SRC_E20, 1'b0, 1'b1, DST_NONE);
      5'd3:    r = mk(SRC_U0,  SRC_E22, 1'b1, 1'b0, DST_C1);
      5'd4:    r = mk(SRC_U0,  SRC_E21, 1'b0, 1'b1, DST_NONE);
      5'd5:    r = mk(SRC_U1,  SRC_E20, 1'b1, 1'b0, DST_C2);
      5'd6:    r = mk(SRC_C0,  SRC_C0,  1'b0, 1'b1, DST_NONE);
      5'd7:    r = mk(SRC_C1,  SRC_C1,  1'b0, 1'b0, DST_NONE);
      5'd8:    r = mk(SRC_C2,  SRC_C2,  1'b0, 1'b0, DST_SQ);
      5'd9:    r = mk(SRC_E31, SRC_E22, 1'b0, 1'b1, DST_NONE);
      5'd10:   r = mk(SRC_E32, SRC_E21, 1'b1, 1'b0, DST_D0);
      5'd11:   r = mk(SRC_E32, SRC_E20, 1'b0, 1'b1, DST_NONE);
      5'd12:   r = mk(SRC_E30, SRC_E22, 1'b1, 1'b0, DST_D1);
      5'd13:   r = mk(SRC_E30, SRC_E21, 1'b0, 1'b1, DST_NONE);
      5'd14:   r = mk(SRC_E31, SRC_E20, 1'b1, 1'b0, DST_D2);
      5'd15:   r = mk(SRC_D0,  SRC_D0,  1'b0, 1'b1, DST_NONE);
      5'd16:   r = mk(SRC_D1,  SRC_D1,  1'b0, 1'b0, DST_NONE);
      5'd17:   r = mk(SRC_D2,  SRC_D2,  1'b0, 1'b0, DST_SQ);
      5'd18:   r = mk(SRC_C0,  SRC_N0,  1'b0, 1'b1, DST_NONE);
      5'd19:   r = mk(SRC_C1,  SRC_N1,  1'b0, 1'b0, DST_NONE);
      5'd20:   r = mk(SRC_C2,  SRC_N2,  1'b0, 1'b0, DST_FLIP);
      5'd21:   r = mk(SRC_U1,  SRC_C2,  1'b0, 1'b1, DST_NONE);
      5'd22:   r = mk(SRC_U2,  SRC_C1,  1'b1, 1'b0, DST_B0);
      5'd23:   r = mk(SRC_U2,  SRC_C0,  1'b0, 1'b1, DST_NONE);
      5'd24:   r = mk(SRC_U0,  SRC_C2,  1'b1, 1'b0, DST_B1);
      5'd25:   r = mk(SRC_U0,  SRC_C1,  1'b0, 1'b1, DST_NONE);
      5'd26:   r = mk(SRC_U1,  SRC_C0,  1'b1, 1'b0, DST_B2);
      default: r = mk(SRC_U0,  SRC_U0,  1'b0, 1'b1, DST_NONE);
    endcase
    return r;
  endfunction

  // Shift right by 16 (quad) or 17 (triangle) with floor, clamp to 48 bits
  function automatic logic [VEC_W-1:0] sat48(logic signed [BR_W-1:0] v, logic quad);
    logic signed [BR_W-1:0] s;
    logic [VEC_W-1:0] r;
    s = quad ? (v >>> SH_QUAD) : (v >>> SH_TRI);
    if (!s[BR_W-1] && (|s[BR_W-2:VEC_W-1])) begin
      r = {1'b0, {(VEC_W-1){1'b1}}};
    end else if (s[BR_W-1] && !(&s[BR_W-2:VEC_W-1])) begin
      r = {1'b1, {(VEC_W-1){1'b0}}};
    end else begin
      r = s[VEC_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mfg_mac.sv
// Signed multiply-accumulate unit, eight multiplier bits per cycle.
`default_nettype none
module mfg_mac
  import mfg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [OP_W-1:0]  a,
  input  wire logic signed [OP_W-1:0]  b,
  input  wire logic                    neg,
  input  wire logic                    first,
  output logic signed [ACC_W-1:0]      acc,
  output logic                         done
);

  localparam int DIG   = 8;
  localparam int NDIG  = (OP_W + DIG - 1) / DIG;
  localparam int MB_W  = NDIG * DIG;
  localparam int P_W   = 2 * OP_W;
  localparam int CNT_W = $clog2(NDIG + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W-1:0]   ma_r;
  logic [MB_W-1:0]  mb_r;
  logic [P_W-1:0]   prod_r;
  logic             sign_r, first_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [OP_W-1:0]      a_mag, b_mag;
  logic [P_W+DIG-1:0]   pp;
  logic signed [ACC_W-1:0] prod_ext, sprod;
  logic                 last_step;

  assign a_mag = a[OP_W-1] ? (~a + 1'b1) : a;
  assign b_mag = b[OP_W-1] ? (~b + 1'b1) : b;
  assign pp = ma_r * mb_r[DIG-1:0];
  assign last_step = (cnt_r == CNT_W'(NDIG));
  assign prod_ext = $signed({{(ACC_W-P_W){1'b0}}, prod_r});
  assign sprod = sign_r ? -prod_ext : prod_ext;

  // Control flags
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && last_step) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Load operands, add one partial product per cycle, then accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r   <= '0;
      ma_r    <= {{(P_W-OP_W){1'b0}}, a_mag};
      mb_r    <= {{(MB_W-OP_W){1'b0}}, b_mag};
      prod_r  <= '0;
      sign_r  <= a[OP_W-1] ^ b[OP_W-1] ^ neg;
      first_r <= first;
    end else if (busy_r && !last_step) begin
      prod_r <= prod_r + pp[P_W-1:0];
      ma_r   <= ma_r << DIG;
      mb_r   <= mb_r >> DIG;
      cnt_r  <= cnt_r + 1'b1;
    end else if (busy_r) begin
      acc_r <= (first_r ? '0 : acc_r) + sprod;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule
`default_nettype wire

// File: rtl/mfg_sqrt.sv
// Integer square root, one result bit per cycle.
`default_nettype none
module mfg_sqrt
  import mfg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [RAD_W-1:0]   rad,
  output logic [ROOT_W-1:0]       root,
  output logic                    done
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [ROOT_W+1:0] rem_sh, trial;
  logic              fits, last_step;

  assign rem_sh = {rem_r[ROOT_W-1:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign last_step = (cnt_r == CNT_W'(ROOT_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && last_step) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Take two radicand bits, try the next root bit
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], fits};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule
`default_nettype wire

// File: rtl/mfg_div.sv
// Three-lane floor divider of the coordinate sums by the vertex count.
`default_nettype none
module mfg_div
  import mfg_pkg::*;
#(
  parameter int N_W = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] sum [NAX],
  input  wire logic [N_W-1:0]          n,
  output logic signed [SUM_W-1:0]      q [NAX],
  output logic                         done
);

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [N_W-1:0]   n_r;
  logic [SUM_W-1:0] dd_r  [NAX];
  logic [N_W-1:0]   rem_r [NAX];
  logic             neg_r [NAX];

  logic [N_W:0]     rem_sh [NAX];
  logic             fits   [NAX];
  logic             last_step;

  assign last_step = (cnt_r == CNT_W'(SUM_W - 1));

  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      rem_sh[k] = {rem_r[k], dd_r[k][SUM_W-1]};
      fits[k]   = (rem_sh[k] >= {1'b0, n_r});
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && last_step) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // A negative sum divides its complement; complementing the quotient floors it
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      n_r   <= n;
      for (int k = 0; k < NAX; k++) begin
        neg_r[k] <= sum[k][SUM_W-1];
        dd_r[k]  <= sum[k][SUM_W-1] ? ~sum[k] : sum[k];
        rem_r[k] <= '0;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      for (int k = 0; k < NAX; k++) begin
        rem_r[k] <= fits[k] ? N_W'(rem_sh[k] - {1'b0, n_r}) : rem_sh[k][N_W-1:0];
        dd_r[k]  <= {dd_r[k][SUM_W-2:0], fits[k]};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      q[k] = neg_r[k] ? ~dd_r[k] : dd_r[k];
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

// File: rtl/mfg_dpath.sv
// Datapath: vertex store, sums, arithmetic units and result selection.
`default_nettype none
module mfg_dpath
  import mfg_pkg::*;
#(
  parameter int MAX_COUNT = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic signed [CW-1:0] in_coord_x,
  input  wire logic signed [CW-1:0] in_coord_y,
  input  wire logic signed [CW-1:0] in_coord_z,
  input  wire cmd_t                 cmd,
  output status_t                   sts,
  output logic [1:0]                out_vector_kind,
  output logic signed [VEC_W-1:0]   out_vec_x,
  output logic signed [VEC_W-1:0]   out_vec_y,
  output logic signed [VEC_W-1:0]   out_vec_z,
  output logic [AREA_W-1:0]         out_area,
  output logic                      out_bad_count,
  output logic                      out_last
);

  localparam int CNT_W = $clog2(MAX_COUNT + 1);

  // Face accumulation state
  logic signed [CW-1:0]    vs_r   [VMAX][NAX];
  logic signed [SUM_W-1:0] csum_r [NAX];
  logic signed [SUM_W-1:0] csum_nxt [NAX];
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // Closing work state
  logic signed [CW-1:0]    p_r    [NAX];
  logic signed [D_W-1:0]   u_r    [NAX];
  logic signed [D_W-1:0]   e2_r   [NAX];
  logic signed [D_W-1:0]   e3_r   [NAX];
  logic signed [SUM_W-1:0] ctr_r  [NAX];
  logic signed [CR_W-1:0]  c_r    [NAX];
  logic signed [OP_W-1:0]  c16_r  [NAX];
  logic signed [OP_W-1:0]  d16_r  [NAX];
  logic signed [BR_W-1:0]  b_r    [NAX];
  logic [AR_W-1:0]         area_r;
  logic                    good_r, quad_r, nzero_r;
  dst_t                    dst_r;

  logic signed [CW-1:0]    pin [NAX];
  logic signed [CW-1:0]    vm  [VMAX][NAX];
  logic signed [SUM_W:0]   sn  [NAX];
  logic signed [OP_W-1:0]  op_a, op_b;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_done, sqrt_done, div_done;
  logic [ROOT_W-1:0]       root;
  logic signed [SUM_W-1:0] q [NAX];
  logic                    acc_pos;
  logic                    face_good;

  assign pin[0] = in_coord_x;
  assign pin[1] = in_coord_y;
  assign pin[2] = in_coord_z;

  // Mask vertices not received for this face
  always_comb begin
    for (int i = 0; i < VMAX; i++) begin
      for (int k = 0; k < NAX; k++) begin
        vm[i][k] = (CNT_W'(i) < cnt_r) ? vs_r[i][k] : '0;
      end
    end
  end

  // Vector from centroid to owner center
  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      sn[k] = {{(SUM_W+1-CW){p_r[k][CW-1]}}, p_r[k]} - {ctr_r[k][SUM_W-1], ctr_r[k]};
    end
  end

  function automatic logic signed [OP_W-1:0] sx_d(logic signed [D_W-1:0] v);
    return {{(OP_W-D_W){v[D_W-1]}}, v};
  endfunction

  function automatic logic signed [OP_W-1:0] pick(src_t s);
    logic signed [OP_W-1:0] r;
    case (s)
      SRC_U0:  r = sx_d(u_r[0]);
      SRC_U1:  r = sx_d(u_r[1]);
      SRC_U2:  r = sx_d(u_r[2]);
      SRC_E20: r = sx_d(e2_r[0]);
      SRC_E21: r = sx_d(e2_r[1]);
      SRC_E22: r = sx_d(e2_r[2]);
      SRC_E30: r = sx_d(e3_r[0]);
      SRC_E31: r = sx_d(e3_r[1]);
      SRC_E32: r = sx_d(e3_r[2]);
      SRC_C0:  r = c16_r[0];
      SRC_C1:  r = c16_r[1];
      SRC_C2:  r = c16_r[2];
      SRC_D0:  r = d16_r[0];
      SRC_D1:  r = d16_r[1];
      SRC_D2:  r = d16_r[2];
      SRC_N0:  r = {{(OP_W-SUM_W-1){sn[0][SUM_W]}}, sn[0]};
      SRC_N1:  r = {{(OP_W-SUM_W-1){sn[1][SUM_W]}}, sn[1]};
      SRC_N2:  r = {{(OP_W-SUM_W-1){sn[2][SUM_W]}}, sn[2]};
      default: r = '0;
    endcase
    return r;
  endfunction

  assign op_a = pick(cmd.uop.a);
  assign op_b = pick(cmd.uop.b);

  mfg_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mac_start),
    .a     (op_a),
    .b     (op_b),
    .neg   (cmd.uop.neg),
    .first (cmd.uop.first),
    .acc   (acc),
    .done  (mac_done)
  );

  mfg_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_done && (dst_r == DST_SQ)),
    .rad   (acc[RAD_W-1:0]),
    .root  (root),
    .done  (sqrt_done)
  );

  mfg_div #(.N_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.close),
    .sum   (csum_r),
    .n     (cnt_r),
    .q     (q),
    .done  (div_done)
  );

  // Sums and count: add a vertex word, clear on a closing word
  always_comb begin
    cnt_nxt = cnt_r;
    for (int k = 0; k < NAX; k++) csum_nxt[k] = csum_r[k];
    if (cmd.vertex && (cnt_r < CNT_W'(MAX_COUNT))) begin
      cnt_nxt = cnt_r + 1'b1;
      for (int k = 0; k < NAX; k++) begin
        csum_nxt[k] = csum_r[k] + {{(SUM_W-CW){pin[k][CW-1]}}, pin[k]};
      end
    end else if (cmd.close) begin
      cnt_nxt = '0;
      for (int k = 0; k < NAX; k++) csum_nxt[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int k = 0; k < NAX; k++) csum_r[k] <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      for (int k = 0; k < NAX; k++) csum_r[k] <= csum_nxt[k];
    end
  end

  // Store the first vertices of the face
  always_ff @(posedge clk) begin
    if (cmd.vertex && (cnt_r < CNT_W'(MAX_COUNT)) && (cnt_r < CNT_W'(VMAX))) begin
      for (int k = 0; k < NAX; k++) vs_r[cnt_r[VIDX_W-1:0]][k] <= pin[k];
    end
  end

  assign face_good = (cnt_r == CNT_W'(3)) || (cnt_r == CNT_W'(4));
  assign acc_pos = !acc[ACC_W-1] && (acc != '0);

  // Closing work: latch edges, then write back unit results
  always_ff @(posedge clk) begin
    if (cmd.close) begin
      good_r  <= face_good;
      quad_r  <= (cnt_r == CNT_W'(4));
      nzero_r <= (cnt_r == '0);
      area_r  <= '0;
      for (int k = 0; k < NAX; k++) begin
        p_r[k]   <= pin[k];
        u_r[k]   <= {vm[1][k][CW-1], vm[1][k]} - {vm[0][k][CW-1], vm[0][k]};
        e2_r[k]  <= {vm[2][k][CW-1], vm[2][k]} - {vm[0][k][CW-1], vm[0][k]};
        e3_r[k]  <= {vm[3][k][CW-1], vm[3][k]} - {vm[0][k][CW-1], vm[0][k]};
        c_r[k]   <= '0;
        c16_r[k] <= '0;
        d16_r[k] <= '0;
        b_r[k]   <= '0;
      end
    end
    if (div_done) begin
      for (int k = 0; k < NAX; k++) ctr_r[k] <= nzero_r ? '0 : q[k];
    end
    if (cmd.mac_start) begin
      dst_r <= cmd.uop.dst;
    end
    if (sqrt_done) begin
      area_r <= area_r + {1'b0, root[ROOT_W-1:1]};
    end
    if (mac_done) begin
      case (dst_r)
        DST_C0: begin c_r[0] <= acc[CR_W-1:0]; c16_r[0] <= acc[CR_W-1:16]; end
        DST_C1: begin c_r[1] <= acc[CR_W-1:0]; c16_r[1] <= acc[CR_W-1:16]; end
        DST_C2: begin c_r[2] <= acc[CR_W-1:0]; c16_r[2] <= acc[CR_W-1:16]; end
        DST_D0: d16_r[0] <= acc[CR_W-1:16];
        DST_D1: d16_r[1] <= acc[CR_W-1:16];
        DST_D2: d16_r[2] <= acc[CR_W-1:16];
        DST_B0: b_r[0] <= acc[BR_W-1:0];
        DST_B1: b_r[1] <= acc[BR_W-1:0];
        DST_B2: b_r[2] <= acc[BR_W-1:0];
        DST_FLIP: begin
          // point the normal away from the owner center
          if (acc_pos) begin
            for (int k = 0; k < NAX; k++) begin
              c_r[k]   <= -c_r[k];
              c16_r[k] <= -c16_r[k];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.div_done  = div_done;
  assign sts.mac_done  = mac_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.good      = good_r;
  assign sts.quad      = quad_r;

  // Select the result word
  logic [VEC_W-1:0] vsel [NAX];
  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      case (cmd.kind)
        KIND_CENTROID: vsel[k] = {{(VEC_W-SUM_W){ctr_r[k][SUM_W-1]}}, ctr_r[k]};
        KIND_NORMAL:   vsel[k] = sat48({{(BR_W-CR_W){c_r[k][CR_W-1]}}, c_r[k]}, quad_r);
        KIND_TANGENT:  vsel[k] = {{(VEC_W-D_W){u_r[k][D_W-1]}}, u_r[k]};
        KIND_BINORMAL: vsel[k] = sat48(b_r[k], quad_r);
        default:       vsel[k] = '0;
      endcase
    end
  end

  assign out_vector_kind = cmd.kind;
  assign out_vec_x = vsel[0];
  assign out_vec_y = vsel[1];
  assign out_vec_z = vsel[2];
  assign out_area  = (|area_r[AR_W-1:AREA_W]) ? {AREA_W{1'b1}} : area_r[AREA_W-1:0];
  assign out_bad_count = !good_r;
  assign out_last  = (cmd.kind == KIND_BINORMAL);

endmodule
`default_nettype wire

// File: rtl/mfg_ctrl.sv
// Controller: handshakes, micro-program sequencing, result word counter.
`default_nettype none
module mfg_ctrl
  import mfg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_req_type,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t sts,
  output cmd_t         cmd
);

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  kind_t           kind_r, kind_nxt;
  uop_t            uop;

  assign uop = uop_rom(pc_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    kind_nxt  = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_req_type) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          pc_nxt    = sts.good ? PC_FIRST : PC_DOT;
          state_nxt = ST_MAC_GO;
        end
      end
      ST_MAC_GO: state_nxt = ST_MAC_WAIT;
      ST_MAC_WAIT: begin
        if (sts.mac_done) begin
          if (uop.dst == DST_SQ) begin
            state_nxt = ST_SQRT_WAIT;
          end else if (pc_r == PC_LAST) begin
            kind_nxt  = KIND_CENTROID;
            state_nxt = ST_OUT;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = ST_MAC_GO;
          end
        end
      end
      ST_SQRT_WAIT: begin
        if (sts.sqrt_done) begin
          // a triangle skips the second half of the quad
          pc_nxt    = (pc_r == PC_SQ1 && !sts.quad) ? PC_DOT : pc_r + 1'b1;
          state_nxt = ST_MAC_GO;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          kind_nxt = kind_t'(kind_r + 1'b1);
          if (kind_r == KIND_BINORMAL) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= PC_FIRST;
      kind_r  <= KIND_CENTROID;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.vertex    = 1'b0;
    cmd.close     = 1'b0;
    cmd.mac_start = 1'b0;
    cmd.uop       = uop;
    cmd.kind      = kind_r;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.vertex = in_valid && !in_req_type;
        cmd.close  = in_valid && in_req_type;
      end
      ST_MAC_GO: cmd.mac_start = 1'b1;
      ST_OUT:    out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/mesh_face_geometry.sv
// Top level of the mesh face geometry block.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    req_type, coord_x/y/z (Q16.16)
//  out      output     out_valid / out_stall  vector_kind, vec_x/y/z, area,
//                                             bad_count, last
//
// After a closing word is taken, the first result word waits for the centroid
// divider, then 9 (bad count), 18 (triangle) or 27 (quad) multiply-accumulates
// on one shared unit taking eight multiplier bits per cycle, and the square roots,
// one for a triangle and two for a quad. Results then leave one per cycle while
// out_stall is low.
// Reset is synchronous and active low; it clears the sums and count.
// Input stalls while a face is being worked on or its results are waiting.
`default_nettype none
module mesh_face_geometry
  import mfg_pkg::*;
#(
  parameter int MAX_COUNT = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire logic signed [CW-1:0] in_coord_x,
  input  wire logic signed [CW-1:0] in_coord_y,
  input  wire logic signed [CW-1:0] in_coord_z,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_vector_kind,
  output logic signed [VEC_W-1:0]   out_vec_x,
  output logic signed [VEC_W-1:0]   out_vec_y,
  output logic signed [VEC_W-1:0]   out_vec_z,
  output logic [AREA_W-1:0]         out_area,
  output logic                      out_bad_count,
  output logic                      out_last
);

  cmd_t    cmd;
  status_t sts;

  mfg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  mfg_dpath #(.MAX_COUNT(MAX_COUNT)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .cmd             (cmd),
    .sts             (sts),
    .out_vector_kind (out_vector_kind),
    .out_vec_x       (out_vec_x),
    .out_vec_y       (out_vec_y),
    .out_vec_z       (out_vec_z),
    .out_area        (out_area),
    .out_bad_count   (out_bad_count),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

// File: tb/tb_mesh_face_geometry.sv
// Testbench for mesh_face_geometry: directed faces plus random faces, checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_mesh_face_geometry;
  import mfg_pkg::*;

  localparam int NUM_ITEMS  = 380;
  localparam int FACE_LIMIT = 15;
  localparam int HOLD_LEN   = 2500;
  localparam int TAIL_LEN   = 700;
  localparam logic signed [127:0] POS47 = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] NEG47 = -128'sh8000_0000_0000;
  localparam logic        REQ_VERTEX = 1'b0;
  localparam logic        REQ_OWNER  = 1'b1;

  typedef struct {
    logic              req;
    logic signed [31:0] x, y, z;
  } point_t;

  typedef struct {
    kind_t       kind;
    logic [47:0] x, y, z;
    logic [46:0] area;
    logic        bad;
    logic        last;
  } geo_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_req_type = 1'b0;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, out_bad_count, out_last;
  logic [1:0] out_vector_kind;
  logic signed [47:0] out_vec_x, out_vec_y, out_vec_z;
  logic [46:0] out_area;

  // negedge copies of block outputs
  logic in_stall_s, out_valid_s, bad_s, last_s;
  logic [1:0] kind_s;
  logic [47:0] vx_s, vy_s, vz_s;
  logic [46:0] area_s;

  geo_t expected_geo[$];
  int errors = 0;
  int faces_closed = 0;
  int results_seen = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // predictor state
  logic signed [31:0] vtx_store[4][3];
  logic signed [39:0] coord_sum[3];
  int vtx_count;

  // directed table
  point_t dir_rows[$];
  bit     dir_typed[$];

  mesh_face_geometry #(.MAX_COUNT(FACE_LIMIT)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_vector_kind(out_vector_kind),
    .out_vec_x(out_vec_x), .out_vec_y(out_vec_y), .out_vec_z(out_vec_z),
    .out_area(out_area), .out_bad_count(out_bad_count), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hold outputs away from the rising edge
  always @(negedge clk) begin
    in_stall_s = in_stall;
    out_valid_s = out_valid;
    kind_s = out_vector_kind;
    vx_s = out_vec_x;
    vy_s = out_vec_y;
    vz_s = out_vec_z;
    area_s = out_area;
    bad_s = out_bad_count;
    last_s = out_last;
  end

  function automatic logic [127:0] int_sqrt(logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int i = 55; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [127:0] half_len(logic signed [127:0] a, logic signed [127:0] b,
                                            logic signed [127:0] c);
    logic signed [127:0] qa, qb, qc;
    qa = a >>> 16;
    qb = b >>> 16;
    qc = c >>> 16;
    return int_sqrt(qa * qa + qb * qb + qc * qc) >> 1;
  endfunction

  function automatic logic [47:0] clamp48(logic signed [127:0] v, int sh);
    logic signed [127:0] s;
    s = v >>> sh;
    if (s > POS47) return POS47[47:0];
    if (s < NEG47) return NEG47[47:0];
    return s[47:0];
  endfunction

  // Fold one accepted word into the face; on the owner word queue four results.
  task automatic predict_face(point_t pt);
    logic signed [127:0] p[3], ctr[3], v[4][3], u[3], e2[3], e3[3];
    logic signed [127:0] c[3], d[3], c16[3], bn[3], dot;
    logic [127:0] ar;
    longint s, q;
    int n, sh;
    bit good;
    geo_t g;
    p[0] = pt.x;
    p[1] = pt.y;
    p[2] = pt.z;
    if (pt.req == REQ_VERTEX) begin
      if (vtx_count < FACE_LIMIT) begin
        for (int k = 0; k < 3; k++) begin
          if (vtx_count < 4) vtx_store[vtx_count][k] = p[k][31:0];
          coord_sum[k] = coord_sum[k] + p[k][39:0];
        end
        vtx_count++;
      end
      return;
    end
    n = vtx_count;
    good = (n == 3 || n == 4);
    sh = (n == 4) ? 16 : 17;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) v[i][k] = (i < n) ? vtx_store[i][k] : 32'sd0;
    for (int k = 0; k < 3; k++) begin
      s = coord_sum[k];
      if (n == 0) q = 0;
      else begin
        q = s / longint'(n);
        if (s % longint'(n) != 0 && s < 0) q--;
      end
      ctr[k] = q;
      u[k] = v[1][k] - v[0][k];
      e2[k] = v[2][k] - v[0][k];
      e3[k] = v[3][k] - v[0][k];
      c[k] = '0;
    end
    ar = '0;
    if (good) begin
      c[0] = u[1] * e2[2] - u[2] * e2[1];
      c[1] = u[2] * e2[0] - u[0] * e2[2];
      c[2] = u[0] * e2[1] - u[1] * e2[0];
      ar = half_len(c[0], c[1], c[2]);
      if (n == 4) begin
        d[0] = e3[1] * e2[2] - e3[2] * e2[1];
        d[1] = e3[2] * e2[0] - e3[0] * e2[2];
        d[2] = e3[0] * e2[1] - e3[1] * e2[0];
        ar = ar + half_len(d[0], d[1], d[2]);
      end
      if (ar > 128'h7FFF_FFFF_FFFF) ar = 128'h7FFF_FFFF_FFFF;
    end
    dot = '0;
    for (int k = 0; k < 3; k++) begin
      c16[k] = c[k] >>> 16;
      dot = dot + c16[k] * (p[k] - ctr[k]);
    end
    // flip a normal that points toward the owner
    if (dot > 0)
      for (int k = 0; k < 3; k++) begin
        c[k] = -c[k];
        c16[k] = -c16[k];
      end
    bn[0] = u[1] * c16[2] - u[2] * c16[1];
    bn[1] = u[2] * c16[0] - u[0] * c16[2];
    bn[2] = u[0] * c16[1] - u[1] * c16[0];
    g.area = ar[46:0];
    g.bad = !good;
    g.last = 1'b0;
    g.kind = KIND_CENTROID;
    g.x = ctr[0][47:0]; g.y = ctr[1][47:0]; g.z = ctr[2][47:0];
    expected_geo.push_back(g);
    g.kind = KIND_NORMAL;
    g.x = clamp48(c[0], sh); g.y = clamp48(c[1], sh); g.z = clamp48(c[2], sh);
    expected_geo.push_back(g);
    g.kind = KIND_TANGENT;
    g.x = u[0][47:0]; g.y = u[1][47:0]; g.z = u[2][47:0];
    expected_geo.push_back(g);
    g.kind = KIND_BINORMAL;
    g.last = 1'b1;
    g.x = clamp48(bn[0], sh); g.y = clamp48(bn[1], sh); g.z = clamp48(bn[2], sh);
    expected_geo.push_back(g);
    for (int k = 0; k < 3; k++) coord_sum[k] = '0;
    vtx_count = 0;
    faces_closed++;
  endtask

  task automatic add_row(logic req, logic signed [31:0] x, logic signed [31:0] y,
                         logic signed [31:0] z, bit typed);
    point_t pt;
    pt.req = req; pt.x = x; pt.y = y; pt.z = z;
    dir_rows.push_back(pt);
    dir_typed.push_back(typed);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed(32'($urandom_range(32'h0020_0000))) - 32'sh0010_0000;
      default: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return -32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // Offer one word, idling first at random, and wait for it to be taken.
  task automatic send_word(point_t pt, bit typed);
    geo_t g;
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= pt.req;
    in_coord_x <= pt.x;
    in_coord_y <= pt.y;
    in_coord_z <= pt.z;
    @(posedge clk);
    while (in_stall_s) @(posedge clk);
    if (typed) begin
      // empty face: everything zero, count flagged
      for (int r = 0; r < 4; r++) begin
        g.kind = kind_t'(r);
        g.x = '0; g.y = '0; g.z = '0; g.area = '0;
        g.bad = 1'b1;
        g.last = (r == 3);
        expected_geo.push_back(g);
      end
      for (int k = 0; k < 3; k++) coord_sum[k] = '0;
      vtx_count = 0;
      faces_closed++;
    end else begin
      predict_face(pt);
    end
  endtask

  // receive side: check accepted words, then pick the next stall
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid_s && !out_stall) begin
        results_seen++;
        if (expected_geo.size() == 0) begin
          $display("%0t: unexpected result kind %0d", $time, kind_s);
          errors++;
        end else begin
          geo_t e;
          e = expected_geo.pop_front();
          if (kind_s !== e.kind || vx_s !== e.x || vy_s !== e.y || vz_s !== e.z ||
              area_s !== e.area || bad_s !== e.bad || last_s !== e.last) begin
            $display("%0t: mismatch expected kind %0d vec %h %h %h area %h bad %b last %b",
                     $time, e.kind, e.x, e.y, e.z, e.area, e.bad, e.last);
            $display("%0t:          actual   kind %0d vec %h %h %h area %h bad %b last %b",
                     $time, kind_s, vx_s, vy_s, vz_s, area_s, bad_s, last_s);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 36);
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // reset, directed table, random faces, drain
  initial begin
    point_t pt;
    int sent, nv, mode, face_no;
    for (int k = 0; k < 3; k++) coord_sum[k] = '0;
    vtx_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(REQ_OWNER, 32'sd0, 32'sd0, 32'sd0, 1'b1);              // empty face
    add_row(REQ_VERTEX, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 1'b0);
    add_row(REQ_OWNER, 32'sd5, 32'sd5, 32'sd5, 1'b0);                // one vertex
    add_row(REQ_VERTEX, 32'sh0001_0000, 32'sd0, 32'sd0, 1'b0);
    add_row(REQ_VERTEX, -32'sh0001_0000, 32'sd0, 32'sd7, 1'b0);
    add_row(REQ_OWNER, 32'sd0, 32'sd0, 32'sd0, 1'b0);                // two vertices
    add_row(REQ_VERTEX, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    add_row(REQ_VERTEX, 32'sh0001_0000, 32'sd0, 32'sd0, 1'b0);
    add_row(REQ_VERTEX, 32'sd0, 32'sh0001_0000, 32'sd0, 1'b0);
    add_row(REQ_OWNER, 32'sd0, 32'sd0, 32'sh0001_0000, 1'b0);        // flipped triangle
    add_row(REQ_VERTEX, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    add_row(REQ_VERTEX, -32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000, 1'b0);
    add_row(REQ_VERTEX, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, 1'b0);
    add_row(REQ_VERTEX, -32'sh8000_0000, -32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    add_row(REQ_OWNER, -32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0); // extreme quad
    add_row(REQ_VERTEX, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    add_row(REQ_VERTEX, 32'sh0002_0000, 32'sd0, 32'sd0, 1'b0);
    add_row(REQ_VERTEX, 32'sh0002_0000, 32'sh0002_0000, 32'sd0, 1'b0);
    add_row(REQ_VERTEX, 32'sd0, 32'sh0002_0000, 32'sd0, 1'b0);
    add_row(REQ_VERTEX, -32'sh0001_0000, -32'sd3, 32'sd9, 1'b0);
    add_row(REQ_OWNER, 32'sd0, 32'sd0, -32'sh0001_0000, 1'b0);       // five vertices
    add_row(REQ_OWNER, -32'sd1, -32'sd1, -32'sd1, 1'b1);             // empty again
    for (int i = 0; i < dir_rows.size(); i++) send_word(dir_rows[i], dir_typed[i]);
    sent = dir_rows.size();

    face_no = 0;
    while (sent < dir_rows.size() + NUM_ITEMS) begin
      if (face_no == 3) hold_req = 1'b1;
      calm = (face_no >= 30 && face_no < 42);
      case ($urandom_range(99)) inside
        [0:74]:  nv = 3 + $urandom_range(1);
        [75:92]: nv = $urandom_range(6);
        default: nv = 14 + $urandom_range(5);
      endcase
      mode = $urandom_range(9) < 4 ? 0 : ($urandom_range(9) < 8 ? 1 : 2);
      for (int i = 0; i <= nv; i++) begin
        pt.req = (i == nv) ? REQ_OWNER : REQ_VERTEX;
        pt.x = rand_coord(mode);
        pt.y = rand_coord(mode);
        pt.z = rand_coord(mode);
        send_word(pt, 1'b0);
        sent++;
      end
      face_no++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (expected_geo.size() != 0) @(posedge clk);
    repeat (TAIL_LEN) @(posedge clk);
    $display("Covered %0d words in %0d faces: empty, short, triangle, quad, long faces,",
             sent, faces_closed);
    $display("extreme coordinates and a long output hold; %0d results checked.", results_seen);
    if (errors == 0 && expected_geo.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
